[rtl/scac_pkg.sv]
// shared types, constants and helper functions for the cache miss classifier
package scac_pkg;

  localparam int unsigned MAX_SETS_LOG2_DEF = 8;
  localparam int unsigned MAX_WAYS_LOG2_DEF = 3;
  localparam int unsigned SEEN_DEPTH_DEF    = 4096;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned WAY_OUT_W  = 3;
  localparam int unsigned LFSR_W     = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  localparam logic [3:0] SETS_LOG2_RST  = 4'd0;
  localparam logic [4:0] BLOCK_LOG2_RST = 5'd4;
  localparam logic [1:0] WAYS_LOG2_RST  = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETS_LOG2  = 2'd0,
    CFG_BLOCK_LOG2 = 2'd1,
    CFG_WAYS_LOG2  = 2'd2,
    CFG_POLICY     = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    POL_LRU    = 2'd0,
    POL_RANDOM = 2'd1,
    POL_FIFO   = 2'd2,
    POL_SPARE  = 2'd3
  } policy_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_HIT        = 2'd0,
    KIND_COMPULSORY = 2'd1,
    KIND_CONFLICT   = 2'd2,
    KIND_CAPACITY   = 2'd3
  } miss_kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SEEN,
    ST_PICK,
    ST_VICTIM,
    ST_FILL,
    ST_WRITE
  } ctrl_state_t;

  typedef enum logic [0:0] {
    SEEN_IDLE,
    SEEN_SCAN
  } seen_state_t;

  typedef struct packed {
    logic done;
    logic seen;
    logic overflow;
  } seen_rsp_t;

  function automatic logic [ADDR_W-1:0] swap_bytes(input logic [ADDR_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] n;
    n = v >> 1;
    if (v[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

[rtl/scac_req_if.sv]
// request channel carrying one raw address word
interface scac_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] raw_address;

  modport source (output valid, output raw_address, input ready);
  modport sink (input valid, input raw_address, output ready);
endinterface

[rtl/scac_rsp_if.sv]
// result channel carrying hit, miss class, way and overflow flag
interface scac_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] miss_kind;
  logic [2:0] way_used;
  logic       seen_overflow;

  modport source (output valid, output hit, output miss_kind, output way_used,
                  output seen_overflow, input ready);
  modport sink (input valid, input hit, input miss_kind, input way_used,
                input seen_overflow, output ready);
endinterface

[rtl/scac_line_ram.sv]
// set-row memory: valid, tag and stamp of every way, one row per set
module scac_line_ram #(
  parameter int unsigned SETS_LOG2 = scac_pkg::MAX_SETS_LOG2_DEF,
  parameter int unsigned WAYS_LOG2 = scac_pkg::MAX_WAYS_LOG2_DEF
) (
  input  logic                                            clk,
  input  logic                                            rd_en,
  input  logic [((SETS_LOG2 > 0) ? SETS_LOG2 : 1)-1:0]    rd_addr,
  input  logic                                            wr_en,
  input  logic [((SETS_LOG2 > 0) ? SETS_LOG2 : 1)-1:0]    wr_addr,
  input  logic [(1 << WAYS_LOG2)-1:0]                     wr_valid,
  input  logic [(1 << WAYS_LOG2)-1:0][scac_pkg::TAG_W-1:0]   wr_tag,
  input  logic [(1 << WAYS_LOG2)-1:0][scac_pkg::STAMP_W-1:0] wr_stamp,
  output logic [(1 << WAYS_LOG2)-1:0]                     rd_valid,
  output logic [(1 << WAYS_LOG2)-1:0][scac_pkg::TAG_W-1:0]   rd_tag,
  output logic [(1 << WAYS_LOG2)-1:0][scac_pkg::STAMP_W-1:0] rd_stamp
);
  localparam int unsigned DEPTH = 1 << SETS_LOG2;
  localparam int unsigned WAYS  = 1 << WAYS_LOG2;

  logic [WAYS-1:0]                          mem_valid [DEPTH];
  logic [WAYS-1:0][scac_pkg::TAG_W-1:0]     mem_tag   [DEPTH];
  logic [WAYS-1:0][scac_pkg::STAMP_W-1:0]   mem_stamp [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_valid[wr_addr] <= wr_valid;
      mem_tag[wr_addr]   <= wr_tag;
      mem_stamp[wr_addr] <= wr_stamp;
    end
    if (rd_en) begin
      rd_valid <= mem_valid[rd_addr];
      rd_tag   <= mem_tag[rd_addr];
      rd_stamp <= mem_stamp[rd_addr];
    end
  end
endmodule

[rtl/scac_seen_scan.sv]
// seen-block store with linear search and append of new block numbers
module scac_seen_scan #(
  parameter int unsigned SEEN_DEPTH = scac_pkg::SEEN_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [scac_pkg::ADDR_W-1:0]   block,
  output scac_pkg::seen_rsp_t           rsp
);
  localparam int unsigned IDX_W = $clog2(SEEN_DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;

  logic [scac_pkg::ADDR_W-1:0] mem [SEEN_DEPTH];
  logic [scac_pkg::ADDR_W-1:0] rd_data;
  logic [scac_pkg::ADDR_W-1:0] key;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            ptr;
  logic                        pending;
  scac_pkg::seen_state_t       state;
  scac_pkg::seen_rsp_t         rsp_r;

  logic match;
  logic finish;
  logic rd_en;
  logic wr_en;
  logic full;

  assign match  = pending && (rd_data == key);
  assign finish = (state == scac_pkg::SEEN_SCAN) && (match || (ptr == count && !pending));
  assign rd_en  = (state == scac_pkg::SEEN_SCAN) && (ptr < count) && !match;
  assign full   = (count == CNT_W'(SEEN_DEPTH));
  assign wr_en  = finish && !match && !full;
  assign rsp    = rsp_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[ptr[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= scac_pkg::SEEN_IDLE;
      count   <= '0;
      ptr     <= '0;
      pending <= 1'b0;
      rsp_r   <= '0;
    end else begin
      rsp_r.done <= finish;
      unique case (state)
        scac_pkg::SEEN_IDLE: begin
          if (start) begin
            key     <= block;
            ptr     <= '0;
            pending <= 1'b0;
            state   <= scac_pkg::SEEN_SCAN;
          end
        end
        scac_pkg::SEEN_SCAN: begin
          pending <= rd_en;
          if (rd_en) begin
            ptr <= ptr + 1'b1;
          end
          if (finish) begin
            rsp_r.seen     <= match;
            rsp_r.overflow <= !match && full;
            if (wr_en) begin
              count <= count + 1'b1;
            end
            state <= scac_pkg::SEEN_IDLE;
          end
        end
        default: state <= scac_pkg::SEEN_IDLE;
      endcase
    end
  end
endmodule

[rtl/set_assoc_cache_miss_classifier.sv]
// a hit passes the lookup and write states; write waits until the result register is free
// a miss adds the seen-block search, a linear scan of the stored block numbers, then the
// pick and fill states, plus stamp compares over the ways, under any policy but random
// requests: one at a time, a new one is taken only in the idle state
// reset: synchronous; the set memory is swept clear, one set after another, before the
// first request is taken; configuration writes are taken at any time
module set_assoc_cache_miss_classifier #(
  parameter int unsigned MAX_SETS_LOG2 = scac_pkg::MAX_SETS_LOG2_DEF,
  parameter int unsigned MAX_WAYS_LOG2 = scac_pkg::MAX_WAYS_LOG2_DEF,
  parameter int unsigned SEEN_DEPTH    = scac_pkg::SEEN_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [scac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scac_pkg::CFG_DATA_W-1:0]   cfg_data,
  scac_req_if.sink                          req,
  scac_rsp_if.source                        rsp
);
  localparam int unsigned SETS   = 1 << MAX_SETS_LOG2;
  localparam int unsigned WAYS   = 1 << MAX_WAYS_LOG2;
  localparam int unsigned SET_W  = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1;
  localparam int unsigned WAY_W  = (MAX_WAYS_LOG2 > 0) ? MAX_WAYS_LOG2 : 1;
  localparam int unsigned LINE_W = MAX_SETS_LOG2 + MAX_WAYS_LOG2 + 1;

  // configuration registers
  logic [3:0]        sets_log2;
  logic [4:0]        block_bytes_log2;
  logic [1:0]        ways_log2;
  scac_pkg::policy_t policy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sets_log2        <= scac_pkg::SETS_LOG2_RST;
      block_bytes_log2 <= scac_pkg::BLOCK_LOG2_RST;
      ways_log2        <= scac_pkg::WAYS_LOG2_RST;
      policy           <= scac_pkg::POL_LRU;
    end else if (cfg_we) begin
      unique case (scac_pkg::cfg_index_t'(cfg_index))
        scac_pkg::CFG_SETS_LOG2:  sets_log2        <= cfg_data[3:0];
        scac_pkg::CFG_BLOCK_LOG2: block_bytes_log2 <= cfg_data[4:0];
        scac_pkg::CFG_WAYS_LOG2:  ways_log2        <= cfg_data[1:0];
        scac_pkg::CFG_POLICY:     policy           <= scac_pkg::policy_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // geometry in use, saturated to what the memory holds
  logic [3:0]        sl;
  logic [2:0]        wl;
  logic [SET_W:0]    set_one;
  logic [SET_W-1:0]  set_mask;
  logic [WAY_W:0]    way_one;
  logic [WAY_W-1:0]  ways_m1_in;
  logic [31:0]       addr_sw;
  logic [31:0]       block_in;
  logic [SET_W-1:0]  set_in;
  logic [31:0]       tag_in;
  logic [LINE_W-1:0] full_lines;

  always_comb begin
    sl         = (32'(sets_log2) > MAX_SETS_LOG2) ? 4'(MAX_SETS_LOG2) : sets_log2;
    wl         = (32'(ways_log2) > MAX_WAYS_LOG2) ? 3'(MAX_WAYS_LOG2) : 3'(ways_log2);
    set_one    = (SET_W + 1)'(1) << sl;
    set_mask   = SET_W'(set_one - 1'b1);
    way_one    = (WAY_W + 1)'(1) << wl;
    ways_m1_in = WAY_W'(way_one - 1'b1);
    addr_sw    = scac_pkg::swap_bytes(req.raw_address);
    block_in   = addr_sw >> block_bytes_log2;
    set_in     = block_in[SET_W-1:0] & set_mask;
    tag_in     = block_in >> sl;
    full_lines = LINE_W'(1) << (sl + 4'(wl));
  end

  // state of one request in flight
  scac_pkg::ctrl_state_t state, state_next;
  logic [31:0]        block_r;
  logic [SET_W-1:0]   set_r;
  logic [31:0]        tag_r;
  logic [WAY_W-1:0]   ways_m1;
  logic               cache_full;
  logic [31:0]        access_count;
  logic [LINE_W-1:0]  valid_lines;
  logic [15:0]        lfsr;
  logic [SET_W-1:0]   clr_ptr;

  logic [WAYS-1:0]              row_valid;
  logic [WAYS-1:0][31:0]        row_tag;
  logic [WAYS-1:0][31:0]        row_stamp;
  logic [WAYS-1:0]              rd_valid;
  logic [WAYS-1:0][31:0]        rd_tag;
  logic [WAYS-1:0][31:0]        rd_stamp;

  logic               free_r;
  logic [WAY_W-1:0]   free_way_r;
  logic               seen_r;
  logic               ovf_r;
  logic [WAY_W-1:0]   way;
  logic [WAY_W-1:0]   vic;
  logic [WAY_W-1:0]   wcnt;
  logic               hit_r;
  scac_pkg::miss_kind_t kind_r;

  // result register toward the consumer
  logic                 out_valid;
  logic                 out_hit;
  scac_pkg::miss_kind_t out_kind;
  logic [2:0]           out_way;
  logic                 out_ovf;
  logic                 out_free;

  assign out_free          = !out_valid || rsp.ready;
  assign rsp.valid         = out_valid;
  assign rsp.hit           = out_hit;
  assign rsp.miss_kind     = out_kind;
  assign rsp.way_used      = out_way;
  assign rsp.seen_overflow = out_ovf;

  // hit and free-way search over the set row just read
  logic                  hit_found;
  logic [WAY_W-1:0]      hit_way;
  logic                  free_found;
  logic [WAY_W-1:0]      free_way;
  logic [WAY_W-1:0]      vic_next;
  logic [WAYS-1:0][31:0] lookup_stamp;

  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) <= ways_m1) begin
        if (!hit_found && rd_valid[w] && rd_tag[w] == tag_r) begin
          hit_found = 1'b1;
          hit_way   = WAY_W'(w);
        end
        if (!free_found && !rd_valid[w]) begin
          free_found = 1'b1;
          free_way   = WAY_W'(w);
        end
      end
    end
    // lru refreshes the stamp of the hit way
    lookup_stamp = rd_stamp;
    if (hit_found && policy == scac_pkg::POL_LRU) begin
      lookup_stamp[hit_way] = access_count;
    end
    // one stamp compare per cycle, lowest way wins ties
    vic_next = (row_stamp[wcnt] < row_stamp[vic]) ? wcnt : vic;
  end

  // seen-block store
  logic                seen_start;
  scac_pkg::seen_rsp_t seen_rsp;

  scac_seen_scan #(
    .SEEN_DEPTH (SEEN_DEPTH)
  ) u_seen (
    .clk   (clk),
    .rst   (rst),
    .start (seen_start),
    .block (block_r),
    .rsp   (seen_rsp)
  );

  // set memory ports
  logic                  line_re;
  logic                  line_we;
  logic [SET_W-1:0]      line_waddr;
  logic [WAYS-1:0]       wr_valid;
  logic [WAYS-1:0][31:0] wr_tag;
  logic [WAYS-1:0][31:0] wr_stamp;

  scac_line_ram #(
    .SETS_LOG2 (MAX_SETS_LOG2),
    .WAYS_LOG2 (MAX_WAYS_LOG2)
  ) u_lines (
    .clk      (clk),
    .rd_en    (line_re),
    .rd_addr  (set_in),
    .wr_en    (line_we),
    .wr_addr  (line_waddr),
    .wr_valid (wr_valid),
    .wr_tag   (wr_tag),
    .wr_stamp (wr_stamp),
    .rd_valid (rd_valid),
    .rd_tag   (rd_tag),
    .rd_stamp (rd_stamp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      scac_pkg::ST_CLEAR:  if (clr_ptr == SET_W'(SETS - 1)) state_next = scac_pkg::ST_IDLE;
      scac_pkg::ST_IDLE:   if (req.valid) state_next = scac_pkg::ST_LOOKUP;
      scac_pkg::ST_LOOKUP: state_next = hit_found ? scac_pkg::ST_WRITE : scac_pkg::ST_SEEN;
      scac_pkg::ST_SEEN:   if (seen_rsp.done) state_next = scac_pkg::ST_PICK;
      scac_pkg::ST_PICK: begin
        if (free_r || policy == scac_pkg::POL_RANDOM || ways_m1 == '0) begin
          state_next = scac_pkg::ST_FILL;
        end else begin
          state_next = scac_pkg::ST_VICTIM;
        end
      end
      scac_pkg::ST_VICTIM: if (wcnt == ways_m1) state_next = scac_pkg::ST_FILL;
      scac_pkg::ST_FILL:   state_next = scac_pkg::ST_WRITE;
      scac_pkg::ST_WRITE:  if (out_free) state_next = scac_pkg::ST_IDLE;
      default:             state_next = scac_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready  = (state == scac_pkg::ST_IDLE);
    line_re    = (state == scac_pkg::ST_IDLE) && req.valid;
    seen_start = (state == scac_pkg::ST_LOOKUP) && !hit_found;
    line_we    = (state == scac_pkg::ST_CLEAR) || (state == scac_pkg::ST_WRITE && out_free);
    if (state == scac_pkg::ST_CLEAR) begin
      line_waddr = clr_ptr;
      wr_valid   = '0;
      wr_tag     = '0;
      wr_stamp   = '0;
    end else begin
      line_waddr = set_r;
      wr_valid   = row_valid;
      wr_tag     = row_tag;
      wr_stamp   = row_stamp;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= scac_pkg::ST_CLEAR;
      clr_ptr      <= '0;
      access_count <= '0;
      valid_lines  <= '0;
      lfsr         <= scac_pkg::LFSR_SEED;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == scac_pkg::ST_CLEAR) begin
        clr_ptr <= clr_ptr + 1'b1;
      end
      if (req.valid && req.ready) begin
        access_count <= access_count + 1'b1;
      end
      // random victim advances the generator once
      if (state == scac_pkg::ST_PICK && !free_r && policy == scac_pkg::POL_RANDOM) begin
        lfsr <= scac_pkg::lfsr_next(lfsr);
      end
      if (state == scac_pkg::ST_FILL && !row_valid[way]) begin
        valid_lines <= valid_lines + 1'b1;
      end
      if (state == scac_pkg::ST_WRITE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    unique case (state)
      scac_pkg::ST_IDLE: begin
        if (req.valid) begin
          block_r    <= block_in;
          set_r      <= set_in;
          tag_r      <= tag_in;
          ways_m1    <= ways_m1_in;
          cache_full <= (valid_lines >= full_lines);
        end
      end
      scac_pkg::ST_LOOKUP: begin
        row_valid  <= rd_valid;
        row_tag    <= rd_tag;
        row_stamp  <= lookup_stamp;
        free_r     <= free_found;
        free_way_r <= free_way;
        hit_r      <= hit_found;
        if (hit_found) begin
          way    <= hit_way;
          kind_r <= scac_pkg::KIND_HIT;
          ovf_r  <= 1'b0;
        end
      end
      scac_pkg::ST_SEEN: begin
        if (seen_rsp.done) begin
          seen_r <= seen_rsp.seen;
          ovf_r  <= seen_rsp.overflow;
        end
      end
      scac_pkg::ST_PICK: begin
        vic  <= '0;
        wcnt <= WAY_W'(1);
        if (free_r) begin
          way    <= free_way_r;
          kind_r <= seen_r ? scac_pkg::KIND_CONFLICT : scac_pkg::KIND_COMPULSORY;
        end else begin
          kind_r <= cache_full ? scac_pkg::KIND_CAPACITY : scac_pkg::KIND_CONFLICT;
          if (policy == scac_pkg::POL_RANDOM) begin
            way <= WAY_W'(scac_pkg::lfsr_next(lfsr)) & ways_m1;
          end else begin
            way <= '0;
          end
        end
      end
      scac_pkg::ST_VICTIM: begin
        vic  <= vic_next;
        wcnt <= wcnt + 1'b1;
        if (wcnt == ways_m1) begin
          way <= vic_next;
        end
      end
      scac_pkg::ST_FILL: begin
        row_valid[way] <= 1'b1;
        row_tag[way]   <= tag_r;
        row_stamp[way] <= access_count;
      end
      scac_pkg::ST_WRITE: begin
        if (out_free) begin
          out_hit  <= hit_r;
          out_kind <= kind_r;
          out_way  <= 3'(way);
          out_ovf  <= ovf_r;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_seen_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    seen_rsp.done |-> state == scac_pkg::ST_SEEN)
    else $error("seen search finished outside its wait state");

  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_hit) |-> (out_kind == scac_pkg::KIND_HIT && !out_ovf))
    else $error("hit result carries a miss class or overflow");

  a_lines_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(valid_lines) <= SETS * WAYS)
    else $error("valid line count beyond the line store");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == scac_pkg::ST_WRITE && line_we) |-> (!out_valid || rsp.ready))
    else $error("result written over one not yet taken");
`endif

endmodule

[verif/set_assoc_cache_miss_classifier_test.sv]
// self-checking testbench for the set-associative cache miss classifier
`timescale 1ns / 100ps

module set_assoc_cache_miss_classifier_test;

  localparam int unsigned SETS_MAX_LOG2 = scac_pkg::MAX_SETS_LOG2_DEF;
  localparam int unsigned WAYS_MAX_LOG2 = scac_pkg::MAX_WAYS_LOG2_DEF;
  localparam int unsigned SEEN_SLOTS    = scac_pkg::SEEN_DEPTH_DEF;
  localparam int unsigned LINE_SLOTS    = (1 << SETS_MAX_LOG2) << WAYS_MAX_LOG2;
  // a miss may scan every stored block number, so the quiet limit covers a full scan
  // plus the longest receiver stall and sender gap, taken several times over
  localparam int unsigned QUIET_LIMIT   = 40000;
  localparam int unsigned DRAIN_CYCLES  = 16;

  typedef struct packed {
    logic                 hit;
    scac_pkg::miss_kind_t miss_kind;
    logic [2:0]           way_used;
    logic                 seen_overflow;
  } lookup_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [scac_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [scac_pkg::CFG_DATA_W-1:0] cfg_data;

  scac_req_if req ();
  scac_rsp_if rsp ();

  set_assoc_cache_miss_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  // predicted cache state, kept in step with every accepted request
  logic             tag_valid [LINE_SLOTS];
  logic [31:0]      tag_value [LINE_SLOTS];
  logic [31:0]      tag_stamp [LINE_SLOTS];
  logic [31:0]      seen_mem [SEEN_SLOTS];
  int unsigned      seen_fill;
  logic [31:0]      lookup_count;
  logic [11:0]      filled_lines;
  logic [15:0]      victim_lfsr;
  logic [3:0]       cur_sets_log2;
  logic [4:0]       cur_block_log2;
  logic [1:0]       cur_ways_log2;
  scac_pkg::policy_t cur_policy;

  lookup_result_t   pending_results[$];

  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  int unsigned stall_phase;
  int unsigned kind_tally [4];
  int unsigned overflow_tally;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reset the cache prediction to its power-up contents
  task automatic clear_prediction();
    for (int i = 0; i < LINE_SLOTS; i++) begin
      tag_valid[i] = 1'b0;
      tag_value[i] = '0;
      tag_stamp[i] = '0;
    end
    seen_fill      = 0;
    lookup_count   = '0;
    filled_lines   = '0;
    victim_lfsr    = scac_pkg::LFSR_SEED;
    cur_sets_log2  = scac_pkg::SETS_LOG2_RST;
    cur_block_log2 = scac_pkg::BLOCK_LOG2_RST;
    cur_ways_log2  = scac_pkg::WAYS_LOG2_RST;
    cur_policy     = scac_pkg::POL_LRU;
  endtask

  // predict one lookup: hit check, then on a miss 3c classification and fill
  task automatic predict_lookup(input logic [31:0] raw);
    int unsigned     sl;
    int unsigned     wl;
    int unsigned     ways;
    logic [31:0]     addr;
    logic [31:0]     blk;
    logic [31:0]     set_idx;
    logic [31:0]     tag;
    int unsigned     base;
    int unsigned     way;
    bit              found;
    bit              seen;
    bit              has_free;
    bit              full;
    lookup_result_t  r;
    sl      = (cur_sets_log2 > SETS_MAX_LOG2) ? SETS_MAX_LOG2 : cur_sets_log2;
    wl      = cur_ways_log2;
    ways    = 1 << wl;
    addr    = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
    blk     = addr >> cur_block_log2;
    set_idx = blk & ((32'd1 << sl) - 32'd1);
    tag     = blk >> sl;
    base    = set_idx << WAYS_MAX_LOG2;
    way     = 0;
    found   = 0;
    seen    = 0;
    has_free = 0;
    lookup_count = lookup_count + 32'd1;
    r = '0;
    for (int w = 0; w < ways; w++) begin
      if (!found && tag_valid[base+w] && tag_value[base+w] == tag) begin
        found = 1;
        way   = w;
      end
    end
    if (found) begin
      // only lru refreshes on a hit
      if (cur_policy == scac_pkg::POL_LRU) tag_stamp[base+way] = lookup_count;
      r.hit       = 1'b1;
      r.miss_kind = scac_pkg::KIND_HIT;
      r.way_used  = way[2:0];
    end else begin
      for (int i = 0; i < seen_fill; i++) begin
        if (seen_mem[i] == blk) seen = 1;
      end
      if (!seen) begin
        if (seen_fill < SEEN_SLOTS) begin
          seen_mem[seen_fill] = blk;
          seen_fill++;
        end else begin
          r.seen_overflow = 1'b1;
        end
      end
      for (int w = 0; w < ways; w++) begin
        if (!has_free && !tag_valid[base+w]) begin
          has_free = 1;
          way      = w;
        end
      end
      full = filled_lines >= ((1 << sl) << wl);
      if (!seen && has_free) r.miss_kind = scac_pkg::KIND_COMPULSORY;
      else if (has_free)     r.miss_kind = scac_pkg::KIND_CONFLICT;
      else r.miss_kind = full ? scac_pkg::KIND_CAPACITY : scac_pkg::KIND_CONFLICT;
      if (!has_free) begin
        if (cur_policy == scac_pkg::POL_RANDOM) begin
          victim_lfsr = (victim_lfsr >> 1) ^ (victim_lfsr[0] ? scac_pkg::LFSR_TAPS : 16'h0);
          way = victim_lfsr & (ways - 1);
        end else begin
          // lru, fifo and the spare code: lowest way with the oldest stamp
          way = 0;
          for (int w = 1; w < ways; w++) begin
            if (tag_stamp[base+w] < tag_stamp[base+way]) way = w;
          end
        end
      end
      if (!tag_valid[base+way]) filled_lines = filled_lines + 12'd1;
      tag_valid[base+way] = 1'b1;
      tag_value[base+way] = tag;
      tag_stamp[base+way] = lookup_count;
      r.way_used = way[2:0];
    end
    pending_results.push_back(r);
  endtask

  // send one request, honoring the burst and gap pattern of the sender
  task automatic send_request(input logic [31:0] raw);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    req.valid       <= 1'b1;
    req.raw_address <= raw;
    do @(posedge clk); while (!(req.valid && req.ready));
    predict_lookup(raw);
    burst_left--;
    @(negedge clk);
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic drain_requests();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write while the block is idle
  task automatic write_register(input scac_pkg::cfg_index_t idx,
                                input logic [scac_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    case (idx)
      scac_pkg::CFG_SETS_LOG2:  cur_sets_log2  = val[3:0];
      scac_pkg::CFG_BLOCK_LOG2: cur_block_log2 = val[4:0];
      scac_pkg::CFG_WAYS_LOG2:  cur_ways_log2  = val[1:0];
      default:                  cur_policy     = scac_pkg::policy_t'(val[1:0]);
    endcase
  endtask

  task automatic set_geometry(input logic [3:0] sets, input logic [4:0] blk,
                              input logic [1:0] ways, input scac_pkg::policy_t pol);
    drain_requests();
    write_register(scac_pkg::CFG_SETS_LOG2, 5'(sets));
    write_register(scac_pkg::CFG_BLOCK_LOG2, blk);
    write_register(scac_pkg::CFG_WAYS_LOG2, 5'(ways));
    write_register(scac_pkg::CFG_POLICY, 5'(pol));
  endtask

  // default geometry: one set, one way; covers hit, compulsory and capacity misses
  task automatic test_reset_geometry();
    send_request(32'h0000_0000);
    send_request(32'h0000_0000);
    send_request(32'hFFFF_FFFF);
    send_request(32'h0000_0000);
    send_request(32'h0100_0000);
    send_request(32'h0000_0001);
  endtask

  // out-of-range sets saturate, widest ways, byte-order and block-size extremes
  task automatic test_geometry_extremes();
    set_geometry(4'd15, 5'd0, 2'd3, scac_pkg::POL_FIFO);
    send_request(32'h0102_0304);
    send_request(32'h0403_0201);
    send_request(32'h0102_0304);
    send_request(32'hAAAA_AAAA);
    send_request(32'h5555_5555);
    // every address maps to block zero or one when the offset covers all but the top bit
    set_geometry(4'd8, 5'd31, 2'd0, scac_pkg::POL_SPARE);
    send_request(32'hDEAD_BEEF);
    send_request(32'h1234_5678);
    // single set, eight ways, random victims: nine tags force a replacement
    set_geometry(4'd0, 5'd16, 2'd3, scac_pkg::POL_RANDOM);
    for (int i = 0; i < 10; i++) send_request({8'h00, 8'h00, 8'(i), 8'h00});
    send_request(32'h0000_0300);
  endtask

  // random traffic from a small address pool per phase to get reuse
  task automatic test_random_traffic(input int unsigned count);
    logic [31:0] pool [32];
    logic [31:0] raw;
    foreach (pool[i]) pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        raw = $urandom;
      end else begin
        raw = pool[$urandom_range(0, 31)];
        // stir the upper nibble of the byte that carries the low address bits
        raw[31:28] = 4'($urandom_range(0, 15));
      end
      send_request(raw);
    end
  endtask

  // receiver stall pattern: always ready, periodically stalled, or coin toss
  initial begin
    rsp.ready = 1'b0;
    stall_phase = 0;
    forever begin
      @(negedge clk);
      stall_phase++;
      case ((stall_phase / 150) % 3)
        0:       rsp.ready <= 1'b1;
        1:       rsp.ready <= (stall_phase % 3) != 0;
        default: rsp.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // compare each result against the oldest prediction, and watch for a hang
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result hit=%0b kind=%0d way=%0d ovf=%0b", $time,
                   rsp.hit, rsp.miss_kind, rsp.way_used, rsp.seen_overflow);
          errors++;
        end else begin
          want = pending_results.pop_front();
          kind_tally[want.miss_kind]++;
          if (want.seen_overflow) overflow_tally++;
          if (rsp.hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp.hit);
            errors++;
          end
          if (rsp.miss_kind !== want.miss_kind) begin
            $display("%0t: miss_kind expected %0d actual %0d", $time,
                     want.miss_kind, rsp.miss_kind);
            errors++;
          end
          if (rsp.way_used !== want.way_used) begin
            $display("%0t: way_used expected %0d actual %0d", $time,
                     want.way_used, rsp.way_used);
            errors++;
          end
          if (rsp.seen_overflow !== want.seen_overflow) begin
            $display("%0t: seen_overflow expected %0b actual %0b", $time,
                     want.seen_overflow, rsp.seen_overflow);
            errors++;
          end
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    errors         = 0;
    quiet_cycles   = 0;
    burst_left     = 0;
    overflow_tally = 0;
    foreach (kind_tally[i]) kind_tally[i] = 0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = scac_pkg::CFG_SETS_LOG2;
    cfg_data        = '0;
    req.valid       = 1'b0;
    req.raw_address = '0;
    clear_prediction();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_geometry();
    test_geometry_extremes();

    // several geometries and every replacement policy, extremes included
    set_geometry(4'd2, 5'd4, 2'd2, scac_pkg::POL_LRU);
    test_random_traffic(200);
    set_geometry(4'd0, 5'd0, 2'd3, scac_pkg::POL_RANDOM);
    test_random_traffic(200);
    set_geometry(4'd8, 5'd16, 2'd1, scac_pkg::POL_FIFO);
    test_random_traffic(150);
    set_geometry(4'd1, 5'd6, 2'd3, scac_pkg::POL_SPARE);
    test_random_traffic(150);
    set_geometry(4'd3, 5'd2, 2'd0, scac_pkg::POL_LRU);
    test_random_traffic(150);
    set_geometry(4'd9, 5'd8, 2'd2, scac_pkg::POL_RANDOM);
    test_random_traffic(150);
    set_geometry(4'd1, 5'd4, 2'd1, scac_pkg::POL_FIFO);
    test_random_traffic(150);
    set_geometry(4'd0, 5'd12, 2'd2, scac_pkg::POL_LRU);
    test_random_traffic(150);
    drain_requests();

    $display("hits %0d, compulsory %0d, conflict %0d, capacity %0d, overflow flags %0d",
             kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], overflow_tally);
    $display("block numbers recorded %0d, lines filled %0d, mismatches %0d",
             seen_fill, filled_lines, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
